### design/vbr_info_header_parser_macros.svh
// Assertion helpers for the VBR header parser.
`ifndef VBR_INFO_HEADER_PARSER_MACROS_SVH
`define VBR_INFO_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define VIP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VIP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VIP_ASSERT(label, clk, rst, prop, msg)
`define VIP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/vip_pkg.sv
package vip_pkg;

  // "Xing" and "Info", first character at index 0
  localparam logic [3:0][7:0] XING_TAG = {8'h67, 8'h6e, 8'h69, 8'h58};
  localparam logic [3:0][7:0] INFO_TAG = {8'h6f, 8'h66, 8'h6e, 8'h49};

  localparam logic [7:0] MPEG1_MASK = 8'h08;
  localparam logic [7:0] NO_CRC_MASK = 8'h01;
  localparam logic [7:0] MONO_MASK = 8'hc0;

  localparam logic [5:0] OFS_BASE = 6'd4;
  localparam logic [5:0] OFS_CRC = 6'd2;
  localparam logic [5:0] OFS_M1_MONO = 6'd17;
  localparam logic [5:0] OFS_M1_STEREO = 6'd32;
  localparam logic [5:0] OFS_M2_MONO = 6'd9;
  localparam logic [5:0] OFS_M2_STEREO = 6'd17;

  localparam logic [6:0] POS_MAX = 7'd127;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd8;
  localparam logic [7:0] FLAGS_END = 8'd8;
  localparam logic [7:0] FIELD_LEN = 8'd4;

  // header_flags bit positions
  localparam int HF_MPEG1 = 0;
  localparam int HF_CRC = 1;
  localparam int HF_MONO = 2;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_value;
    logic       last_byte;
  } stage_t;

endpackage

### design/vip_byte_if.sv
interface vip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

### design/vip_result_if.sv
interface vip_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        is_variable;
  logic [31:0] frame_count;
  logic [31:0] byte_count;

  modport source (output valid, output found, output is_variable, output frame_count,
                  output byte_count, input ready);
  modport sink (input valid, input found, input is_variable, input frame_count,
                input byte_count, output ready);
endinterface

### design/vip_in_stage.sv
module vip_in_stage
  import vip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  vip_byte_if.sink   byte_in,
  input  logic       take,
  output stage_t     stage
);

  stage_t stage_next;

  assign byte_in.ready = !stage.valid || take;

  always_comb begin
    stage_next = stage;
    if (byte_in.ready) begin
      stage_next.valid = byte_in.valid;
      stage_next.byte_value = byte_in.byte_value;
      stage_next.last_byte = byte_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    stage.byte_value <= stage_next.byte_value;
    stage.last_byte <= stage_next.last_byte;
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
  end

endmodule

### design/vip_parse_core.sv
`include "vbr_info_header_parser_macros.svh"

module vip_parse_core
  import vip_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  output logic         take,
  vip_result_if.source result_out
);

  logic [6:0]  position, position_next;
  logic [2:0]  header_flags, header_flags_next;
  logic [5:0]  tag_offset, tag_offset_next;
  logic        xing_match, xing_match_next;
  logic        info_match, info_match_next;
  logic [1:0]  field_flags, field_flags_next;
  logic [31:0] frames_seen, frames_seen_next;
  logic [31:0] bytes_seen, bytes_seen_next;

  logic        res_valid;
  logic        res_found, res_var;
  logic [31:0] res_frames, res_bytes;

  logic [7:0]  b;
  logic [6:0]  rel;
  logic        in_tag;
  logic [5:0]  ofs_calc;
  logic [7:0]  len, at8, at12, at_bytes;
  logic        ok_base, ok_frames, ok_final;
  logic [31:0] frames_out, bytes_out;

  assign b = stage.byte_value;
  assign take = stage.valid && (!stage.last_byte || !res_valid || result_out.ready);

  always_comb begin
    header_flags_next = header_flags;
    tag_offset_next = tag_offset;
    xing_match_next = xing_match;
    info_match_next = info_match;
    field_flags_next = field_flags;
    frames_seen_next = frames_seen;
    bytes_seen_next = bytes_seen;
    ofs_calc = OFS_BASE;

    if (position == 7'd1) begin
      if ((b & MPEG1_MASK) != 8'd0) header_flags_next[HF_MPEG1] = 1'b1;
      if ((b & NO_CRC_MASK) == 8'd0) header_flags_next[HF_CRC] = 1'b1;
    end else if (position == 7'd3) begin
      if ((b & MONO_MASK) == MONO_MASK) header_flags_next[HF_MONO] = 1'b1;
      if (header_flags_next[HF_CRC]) ofs_calc = ofs_calc + OFS_CRC;
      unique case ({header_flags_next[HF_MPEG1], header_flags_next[HF_MONO]})
        2'b11:   ofs_calc = ofs_calc + OFS_M1_MONO;
        2'b10:   ofs_calc = ofs_calc + OFS_M1_STEREO;
        2'b01:   ofs_calc = ofs_calc + OFS_M2_MONO;
        default: ofs_calc = ofs_calc + OFS_M2_STEREO;
      endcase
      tag_offset_next = ofs_calc;
    end

    // tag offset is set once byte 3 is in, so it is valid from byte 4 on
    in_tag = (position >= 7'd4) && (tag_offset != 6'd0) && (position >= {1'b0, tag_offset});
    rel = position - {1'b0, tag_offset};

    if (in_tag) begin
      if (rel < 7'd4) begin
        if (b != XING_TAG[rel[1:0]]) xing_match_next = 1'b0;
        if (b != INFO_TAG[rel[1:0]]) info_match_next = 1'b0;
      end else if (rel == 7'd7) begin
        field_flags_next = b[1:0];
      end else if (rel >= 7'd8 && rel < 7'd12) begin
        if (field_flags[0]) begin
          frames_seen_next = {frames_seen[23:0], b};
        end else if (field_flags[1]) begin
          bytes_seen_next = {bytes_seen[23:0], b};
        end
      end else if (rel >= 7'd12 && rel < 7'd16) begin
        if (field_flags == 2'b11) bytes_seen_next = {bytes_seen[23:0], b};
      end
    end

    position_next = (position < POS_MAX) ? position + 7'd1 : position;
  end

  // end-of-frame evaluation on the updated state
  always_comb begin
    len = {1'b0, position} + 8'd1;
    at8 = {2'b00, tag_offset_next} + FLAGS_END;
    at12 = at8 + FIELD_LEN;
    at_bytes = field_flags_next[0] ? at12 : at8;
    ok_base = (len >= MIN_FRAME_LEN) && (at8 <= len) && (xing_match_next || info_match_next);
    ok_frames = ok_base && (!field_flags_next[0] || at12 <= len);
    frames_out = field_flags_next[0] ? frames_seen_next : 32'd0;
    ok_final = ok_frames && (frames_out != 32'd0);
    bytes_out = (field_flags_next[1] && at_bytes + FIELD_LEN <= len) ? bytes_seen_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 7'd0;
      header_flags <= 3'd0;
      tag_offset <= 6'd0;
      xing_match <= 1'b1;
      info_match <= 1'b1;
      field_flags <= 2'd0;
      frames_seen <= 32'd0;
      bytes_seen <= 32'd0;
    end else if (take) begin
      if (stage.last_byte) begin
        // drop all frame state, ready for the next frame
        position <= 7'd0;
        header_flags <= 3'd0;
        tag_offset <= 6'd0;
        xing_match <= 1'b1;
        info_match <= 1'b1;
        field_flags <= 2'd0;
        frames_seen <= 32'd0;
        bytes_seen <= 32'd0;
      end else begin
        position <= position_next;
        header_flags <= header_flags_next;
        tag_offset <= tag_offset_next;
        xing_match <= xing_match_next;
        info_match <= info_match_next;
        field_flags <= field_flags_next;
        frames_seen <= frames_seen_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && stage.last_byte) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.last_byte) begin
      res_found <= ok_final;
      res_var <= ok_final && xing_match_next;
      res_frames <= ok_final ? frames_out : 32'd0;
      res_bytes <= ok_final ? bytes_out : 32'd0;
    end
  end

  assign result_out.valid = res_valid;
  assign result_out.found = res_found;
  assign result_out.is_variable = res_var;
  assign result_out.frame_count = res_frames;
  assign result_out.byte_count = res_bytes;

  `VIP_ASSERT(a_not_found_zero, clk, rst,
    res_valid && !res_found |-> !res_var && res_frames == 32'd0 && res_bytes == 32'd0,
    "not-found result carries nonzero fields")
  `VIP_ASSERT(a_result_from_last, clk, rst,
    res_valid && !$past(res_valid) |-> $past(take && stage.last_byte),
    "result appeared without a last byte")
  `VIP_ASSERT(a_frame_restart, clk, rst,
    take && stage.last_byte |=> position == 7'd0 && xing_match && info_match,
    "state not cleared after last byte")
  `VIP_ASSERT(a_position_step, clk, rst,
    take && !stage.last_byte && position != POS_MAX |=> position == $past(position) + 7'd1,
    "position did not advance")
  `VIP_ASSERT_ALWAYS(a_reset_clears, clk,
    rst |=> !res_valid && position == 7'd0,
    "reset did not clear control state")

endmodule

### design/vbr_info_header_parser.sv
// channel     | dir | payload
// ------------+-----+---------------------------------------------
// byte_in     | in  | byte_value[7:0], last_byte
// result_out  | out | found, is_variable, frame_count[31:0], byte_count[31:0]
//
// One byte per cycle unless a waiting result stalls the input; each byte passes an input register and the parse logic.
// A result is registered when its last byte is taken from the input register; other bytes give none.
// Synchronous active-high reset clears the frame state and both valid flags.
// A waiting result stalls the input only when the next last byte reaches the parser.
module vbr_info_header_parser
  import vip_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  vip_byte_if.sink     byte_in,
  vip_result_if.source result_out
);

  stage_t stage;
  logic   take;

  vip_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .take    (take),
    .stage   (stage)
  );

  vip_parse_core u_parse_core (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .take       (take),
    .result_out (result_out)
  );

endmodule
